>>> rtl/core/owgd_pkg.sv
// shared types, codes and constants of the occupancy weighted grid distance block
`default_nettype none

package owgd_pkg;

  // fixed field widths
  localparam int COORD_W  = 4;
  localparam int CFG_W    = 10;
  localparam int DCNT_W   = 4;
  localparam int SLOT_W   = 3;
  localparam int MODE_W   = 2;
  localparam int REGIDX_W = 2;
  localparam int COST_W   = 16;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // parameter defaults
  localparam int GRID_SIZE_DEF        = 16;
  localparam int MAX_DESTINATIONS_DEF = 8;

  // register reset values
  localparam logic [CFG_W-1:0]  STEP_WEIGHT_RST      = 10'd124;
  localparam logic [CFG_W-1:0]  OCCUPIED_PENALTY_RST = 10'd64;
  localparam logic [DCNT_W-1:0] DEST_COUNT_RST       = 4'd0;

  // register indexes
  localparam logic [REGIDX_W-1:0] REG_STEP_WEIGHT      = 2'd0;
  localparam logic [REGIDX_W-1:0] REG_OCCUPIED_PENALTY = 2'd1;
  localparam logic [REGIDX_W-1:0] REG_DEST_COUNT       = 2'd2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_GRID_WR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEST_WR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GRID_WB,
    ST_WALK,
    ST_DONE
  } owgd_state_t;

  // grid access: read issue, write back of one cell
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               occ;
  } grid_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } dest_ent_t;

endpackage

`default_nettype wire

>>> rtl/core/owgd_grid.sv
// occupancy grid held twice: row-major and column-major memories with row and column valid bits
`default_nettype none

module owgd_grid import owgd_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire grid_req_t            req,
  output logic      [GRID_SIZE-1:0] row_word,
  output logic      [GRID_SIZE-1:0] col_word
);

  localparam int GW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

  logic [GRID_SIZE-1:0] row_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] col_mem [GRID_SIZE];

  logic [GRID_SIZE-1:0] row_vld_r;
  logic [GRID_SIZE-1:0] col_vld_r;
  logic [GRID_SIZE-1:0] row_q_r;
  logic [GRID_SIZE-1:0] col_q_r;
  logic                 row_ok_r;
  logic                 col_ok_r;

  logic [GW-1:0]        xa;
  logic [GW-1:0]        ya;
  logic                 x_in;
  logic                 y_in;
  logic                 wr_ok;
  logic [GRID_SIZE-1:0] row_mod;
  logic [GRID_SIZE-1:0] col_mod;

  assign xa    = GW'(req.x);
  assign ya    = GW'(req.y);
  assign x_in  = 32'(req.x) < 32'(GRID_SIZE);
  assign y_in  = 32'(req.y) < 32'(GRID_SIZE);
  assign wr_ok = req.wr && x_in && y_in;

  // rows and columns never written read as free
  assign row_word = row_ok_r ? row_q_r : '0;
  assign col_word = col_ok_r ? col_q_r : '0;

  // modify step of the cell write
  always_comb begin
    row_mod     = row_word;
    col_mod     = col_word;
    row_mod[xa] = req.occ;
    col_mod[ya] = req.occ;
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      row_q_r <= row_mem[ya];
      col_q_r <= col_mem[xa];
    end
    if (wr_ok) begin
      row_mem[ya] <= row_mod;
      col_mem[xa] <= col_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      col_vld_r <= '0;
      row_ok_r  <= 1'b0;
      col_ok_r  <= 1'b0;
    end else begin
      if (req.rd) begin
        row_ok_r <= y_in && row_vld_r[ya];
        col_ok_r <= x_in && col_vld_r[xa];
      end
      if (wr_ok) begin
        row_vld_r[ya] <= 1'b1;
        col_vld_r[xa] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/owgd_dest.sv
// destination table memory, one write and one registered read per cycle
`default_nettype none

module owgd_dest import owgd_pkg::*; #(
  parameter int MAX_DESTINATIONS = MAX_DESTINATIONS_DEF,
  localparam int DAW = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic  [SLOT_W-1:0] wr_slot,
  input  wire dest_ent_t          wr_ent,
  input  wire logic               rd_en,
  input  wire logic     [DAW-1:0] rd_addr,
  output dest_ent_t               rd_ent
);

  dest_ent_t mem [MAX_DESTINATIONS];
  dest_ent_t q_r;
  logic      wr_ok;

  assign wr_ok  = wr_en && (32'(wr_slot) < 32'(MAX_DESTINATIONS));
  assign rd_ent = q_r;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[DAW'(wr_slot)] <= wr_ent;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/owgd_cost.sv
// per-destination cost pipeline: segment masks, hit count, products, saturate and minimum
`default_nettype none

module owgd_cost import owgd_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 vld,
  input  wire dest_ent_t            dest,
  input  wire logic   [COORD_W-1:0] tgt_x,
  input  wire logic   [COORD_W-1:0] tgt_y,
  input  wire logic [GRID_SIZE-1:0] row_word,
  input  wire logic [GRID_SIZE-1:0] col_word,
  input  wire logic     [CFG_W-1:0] step_weight,
  input  wire logic     [CFG_W-1:0] occupied_penalty,
  output logic                      busy,
  output logic       [COST_W-1:0]   best
);

  localparam int DSTW = COORD_W + 1;
  localparam int HW   = $clog2(2 * GRID_SIZE + 1);
  localparam int PAW  = DSTW + CFG_W;
  localparam int PBW  = HW + CFG_W;
  localparam int SW   = ((PAW > PBW) ? PAW : PBW) + 1;

  logic [GRID_SIZE-1:0] rmask;
  logic [GRID_SIZE-1:0] cmask;
  logic [COORD_W-1:0]   dx;
  logic [COORD_W-1:0]   dy;

  logic                 v1_r, v2_r, v3_r;
  logic [GRID_SIZE-1:0] seg_row_r;
  logic [GRID_SIZE-1:0] seg_col_r;
  logic [DSTW-1:0]      dist1_r;
  logic [DSTW-1:0]      dist2_r;
  logic [HW-1:0]        hits_r;
  logic [PAW-1:0]       pa_r;
  logic [PBW-1:0]       pb_r;
  logic [SW-1:0]        sum;
  logic [COST_W-1:0]    cost;
  logic [COST_W-1:0]    best_r;

  // cells on the target row and column between target and destination
  always_comb begin
    for (int k = 0; k < GRID_SIZE; k++) begin
      if (tgt_x < dest.x) begin
        rmask[k] = (k >= int'(tgt_x)) && (k < int'(dest.x));
      end else begin
        rmask[k] = (k > int'(dest.x)) && (k <= int'(tgt_x));
      end
      if (tgt_y < dest.y) begin
        cmask[k] = (k >= int'(tgt_y)) && (k < int'(dest.y));
      end else begin
        cmask[k] = (k > int'(dest.y)) && (k <= int'(tgt_y));
      end
    end
  end

  assign dx = (tgt_x > dest.x) ? (tgt_x - dest.x) : (dest.x - tgt_x);
  assign dy = (tgt_y > dest.y) ? (tgt_y - dest.y) : (dest.y - tgt_y);

  assign sum  = SW'(pa_r) + SW'(pb_r);
  assign cost = (32'(sum) > 32'(COST_MAX)) ? COST_MAX : COST_W'(sum);
  assign busy = v1_r || v2_r || v3_r;
  assign best = best_r;

  always_ff @(posedge clk) begin
    seg_row_r <= rmask & row_word;
    seg_col_r <= cmask & col_word;
    dist1_r   <= DSTW'(dx) + DSTW'(dy);
    hits_r    <= HW'($countones(seg_row_r)) + HW'($countones(seg_col_r));
    dist2_r   <= dist1_r;
    pa_r      <= PAW'(dist2_r) * PAW'(step_weight);
    pb_r      <= PBW'(hits_r) * PBW'(occupied_penalty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      best_r <= COST_MAX;
    end else begin
      v1_r <= vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (start) begin
        best_r <= COST_MAX;
      end else if (v3_r && (cost < best_r)) begin
        best_r <= cost;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/occupancy_weighted_grid_distance.sv
// top level of the occupancy weighted grid distance block: registers, sequencer, result register
//
//  channel  signals                                      direction  role
//  in       in_valid/in_ready, in_mode, in_cell_x,
//           in_cell_y, in_occupied, in_dest_index        input      request stream
//  out      out_valid/out_ready, out_heuristic_value,
//           out_no_destination                           output     one result per query
//  cfg      cfg_we, cfg_index, cfg_wdata                 input      register writes
//
// a destination write is done on acceptance; a grid cell write reads row and column, then writes back
// a query for n destinations reads the destination memory once per cycle, feeding a four-stage
// cost pipeline, then the result is loaded into the out register
// synchronous active-low reset clears the grid valid bits and registers; no clearing pass
// in_ready is low while a request is being worked; a finished query waits in ST_DONE
// only while the previous result is still held in the out register
`default_nettype none

module occupancy_weighted_grid_distance import owgd_pkg::*; #(
  parameter int GRID_SIZE        = GRID_SIZE_DEF,
  parameter int MAX_DESTINATIONS = MAX_DESTINATIONS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic   [MODE_W-1:0] in_mode,
  input  wire logic  [COORD_W-1:0] in_cell_x,
  input  wire logic  [COORD_W-1:0] in_cell_y,
  input  wire logic                in_occupied,
  input  wire logic   [SLOT_W-1:0] in_dest_index,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [COST_W-1:0]   out_heuristic_value,
  output logic                     out_no_destination,
  // register writes
  input  wire logic                cfg_we,
  input  wire logic [REGIDX_W-1:0] cfg_index,
  input  wire logic    [CFG_W-1:0] cfg_wdata
);

  localparam int DAW  = (MAX_DESTINATIONS > 1) ? $clog2(MAX_DESTINATIONS) : 1;
  localparam int CNTW = $clog2(MAX_DESTINATIONS + 1);

  // configuration registers
  logic [CFG_W-1:0]  step_weight_r;
  logic [CFG_W-1:0]  occupied_penalty_r;
  logic [DCNT_W-1:0] dest_count_r;

  // sequencer
  owgd_state_t       state_r, state_nxt;
  logic [CNTW-1:0]   issue_idx_r, issue_idx_nxt;
  logic              rd_vld_r;
  logic [COORD_W-1:0] tgt_x_r, tgt_y_r;
  logic              occ_r;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [COST_W-1:0] out_value_r;
  logic              out_nodest_r;

  logic              in_acc;
  logic              issue;
  logic              load_out;
  logic [CNTW-1:0]   eff_cnt;

  grid_req_t         greq;
  logic [GRID_SIZE-1:0] row_word, col_word;
  dest_ent_t         wr_ent, rd_ent;
  logic              cost_busy;
  logic [COST_W-1:0] best;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // counts above the table depth walk the whole table
  assign eff_cnt = (32'(dest_count_r) > 32'(MAX_DESTINATIONS)) ?
                   CNTW'(MAX_DESTINATIONS) : CNTW'(dest_count_r);

  assign issue = (state_r == ST_WALK) && (issue_idx_r != eff_cnt);

  // grid read on accepting a cell write or a query, write back in the following cycle
  always_comb begin
    greq.rd  = in_acc && ((in_mode == MODE_GRID_WR) || (in_mode == MODE_QUERY));
    greq.wr  = (state_r == ST_GRID_WB);
    greq.x   = in_ready ? in_cell_x : tgt_x_r;
    greq.y   = in_ready ? in_cell_y : tgt_y_r;
    greq.occ = occ_r;
  end

  assign wr_ent.x = in_cell_x;
  assign wr_ent.y = in_cell_y;

  owgd_grid #(
    .GRID_SIZE(GRID_SIZE)
  ) u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (greq),
    .row_word(row_word),
    .col_word(col_word)
  );

  owgd_dest #(
    .MAX_DESTINATIONS(MAX_DESTINATIONS)
  ) u_dest (
    .clk    (clk),
    .wr_en  (in_acc && (in_mode == MODE_DEST_WR)),
    .wr_slot(in_dest_index),
    .wr_ent (wr_ent),
    .rd_en  (issue),
    .rd_addr(issue_idx_r[DAW-1:0]),
    .rd_ent (rd_ent)
  );

  owgd_cost #(
    .GRID_SIZE(GRID_SIZE)
  ) u_cost (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (in_acc && (in_mode == MODE_QUERY)),
    .vld             (rd_vld_r),
    .dest            (rd_ent),
    .tgt_x           (tgt_x_r),
    .tgt_y           (tgt_y_r),
    .row_word        (row_word),
    .col_word        (col_word),
    .step_weight     (step_weight_r),
    .occupied_penalty(occupied_penalty_r),
    .busy            (cost_busy),
    .best            (best)
  );

  // next state, walk counter and result handshake
  always_comb begin
    state_nxt     = state_r;
    issue_idx_nxt = issue_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load_out      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_GRID_WR) begin
            state_nxt = ST_GRID_WB;
          end else if (in_mode == MODE_QUERY) begin
            state_nxt     = ST_WALK;
            issue_idx_nxt = '0;
          end
        end
      end
      ST_GRID_WB: begin
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        if (issue) begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end else if (!rd_vld_r && !cost_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // out register free or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      issue_idx_r        <= '0;
      rd_vld_r           <= 1'b0;
      out_valid_r        <= 1'b0;
      step_weight_r      <= STEP_WEIGHT_RST;
      occupied_penalty_r <= OCCUPIED_PENALTY_RST;
      dest_count_r       <= DEST_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      issue_idx_r <= issue_idx_nxt;
      rd_vld_r    <= issue;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_WEIGHT:      step_weight_r      <= cfg_wdata;
          REG_OCCUPIED_PENALTY: occupied_penalty_r <= cfg_wdata;
          REG_DEST_COUNT:       dest_count_r       <= cfg_wdata[DCNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // request payload and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_x_r <= in_cell_x;
      tgt_y_r <= in_cell_y;
      occ_r   <= in_occupied;
    end
    if (load_out) begin
      out_value_r  <= best;
      out_nodest_r <= (eff_cnt == '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_heuristic_value = out_value_r;
  assign out_no_destination  = out_nodest_r;

endmodule

`default_nettype wire
